// ===== rtl/ips_pkg.sv =====
// ----------------------------------------------------------------------------
// ips_pkg: shared types and constants of the impact peak scorer
// Field widths, register indexes, reset values and the queued command type.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int AXIS_W          = 16;
  localparam int ENERGY_W        = 32;
  localparam int SCORE_W         = 10;
  localparam int NUM_W           = ENERGY_W + SCORE_W;
  localparam int CNT_W           = 8;
  localparam int DECAY_W         = 3;

  localparam logic [SCORE_W-1:0] MAX_SCORE   = SCORE_W'(1000);
  localparam logic [DECAY_W-1:0] DECAY_TICKS = DECAY_W'(4);
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  // command queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = CFG_IDX_W'(1);

  localparam logic [ENERGY_W-1:0] FULL_SCALE_RST   = ENERGY_W'(100000000);
  localparam logic [CNT_W-1:0]    WINDOW_TICKS_RST = CNT_W'(48);

  typedef struct packed {
    logic                func;    // 0 = start window, 1 = sample
    logic [ENERGY_W-1:0] energy;  // x*x + y*y + z*z
  } cmd_t;

endpackage

// ===== rtl/ips_if.sv =====
// ----------------------------------------------------------------------------
// ips_if: valid/ready channels of the impact peak scorer
// Input channel carries start and sample items, output channel the results.
// ----------------------------------------------------------------------------
interface ips_in_if;
  import ips_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, func, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, func, accel_x, accel_y, accel_z, output ready);
endinterface

interface ips_out_if;
  import ips_pkg::*;

  logic               valid;
  logic               ready;
  logic               window_done;
  logic [SCORE_W-1:0] impact_score;
  logic               impact_seen;
  logic               window_open;

  modport source (output valid, window_done, impact_score, impact_seen, window_open,
                  input ready);
  modport sink   (input valid, window_done, impact_score, impact_seen, window_open,
                  output ready);
endinterface

// ===== rtl/impact_peak_scorer.sv =====
// Path: a start or sample passes the front stage, command queue, back-end command
//   register and result register; a sample that closes the window also passes
//   ST_MUL, ST_START and, unless saturated, the 10-step divider. Back end takes one
//   at a time; front stage and 2-entry queue accept while it is busy, until full.
// Reset: synchronous rst_n clears window state and queue, sets config to defaults.
// ----------------------------------------------------------------------------
// impact_peak_scorer: impact strength score from 3-axis accelerometer samples
// Front stage squares the axes, a command queue feeds the scoring back end.
// ----------------------------------------------------------------------------
module impact_peak_scorer #(
  parameter int SAMPLE_BITS = ips_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ips_in_if.sink                         in_ch,
  ips_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ips_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ips_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ips_pkg::*;

  logic [ENERGY_W-1:0] full_scale_r, full_scale_nxt;
  logic [CNT_W-1:0]    window_ticks_r, window_ticks_nxt;

  cmd_t push_cmd, pop_cmd;
  logic push_vld, push_rdy, pop_vld, pop;

  always_comb begin
    full_scale_nxt   = full_scale_r;
    window_ticks_nxt = window_ticks_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FULL_SCALE:   full_scale_nxt   = ENERGY_W'(cfg_wdata);
        CFG_WINDOW_TICKS: window_ticks_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r   <= FULL_SCALE_RST;
      window_ticks_r <= WINDOW_TICKS_RST;
    end else begin
      full_scale_r   <= full_scale_nxt;
      window_ticks_r <= window_ticks_nxt;
    end
  end

  ips_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push_cmd (push_cmd),
    .push_vld (push_vld),
    .push_rdy (push_rdy)
  );

  ips_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cmd (push_cmd),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .pop_cmd  (pop_cmd),
    .pop_vld  (pop_vld),
    .pop      (pop)
  );

  ips_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_cmd      (pop_cmd),
    .pop_vld      (pop_vld),
    .pop          (pop),
    .full_scale   (full_scale_r),
    .window_ticks (window_ticks_r),
    .out_ch       (out_ch)
  );

endmodule

// ===== rtl/ips_front.sv =====
// ----------------------------------------------------------------------------
// ips_front: input stage of the impact peak scorer
// Accepts transactions, squares the three axes and forms queue commands.
// ----------------------------------------------------------------------------
module ips_front #(
  parameter int SAMPLE_BITS = ips_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ips_in_if.sink       in_ch,
  output ips_pkg::cmd_t push_cmd,
  output logic         push_vld,
  input  logic         push_rdy
);
  import ips_pkg::*;

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = SQ_W + 2;

  // square of the low SAMPLE_BITS bits taken as two's complement
  function automatic logic [SQ_W-1:0] axis_sq(input logic [AXIS_W-1:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] mag;
    v   = raw[SAMPLE_BITS-1:0];
    mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  logic            s_vld_r, s_vld_nxt;
  logic            s_func_r;
  logic [SQ_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic            take;

  assign in_ch.ready = !s_vld_r || push_rdy;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    s_vld_nxt = s_vld_r;
    if (take) begin
      s_vld_nxt = 1'b1;
    end else if (push_rdy) begin
      s_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= s_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_func_r <= in_ch.func;
      sq_x_r   <= axis_sq(in_ch.accel_x);
      sq_y_r   <= axis_sq(in_ch.accel_y);
      sq_z_r   <= axis_sq(in_ch.accel_z);
    end
  end

  assign push_vld        = s_vld_r;
  assign push_cmd.func   = s_func_r;
  assign push_cmd.energy = ENERGY_W'(SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r));

endmodule

// ===== rtl/ips_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ips_cmd_fifo: command queue between front and back end
// Small register queue so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ips_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  ips_pkg::cmd_t push_cmd,
  input  logic          push_vld,
  output logic          push_rdy,
  output ips_pkg::cmd_t pop_cmd,
  output logic          pop_vld,
  input  logic          pop
);
  import ips_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_ok, pop_ok;

  assign push_rdy = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_cmd  = mem_r[rd_ptr_r];
  assign push_ok  = push_vld && push_rdy;
  assign pop_ok   = pop && pop_vld;

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push_ok) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/ips_div.sv =====
// ----------------------------------------------------------------------------
// ips_div: restoring divider for the score
// One quotient bit per cycle; the caller guarantees a quotient below 2**SCORE_W.
// ----------------------------------------------------------------------------
module ips_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ips_pkg::NUM_W-1:0]    num,
  input  logic [ips_pkg::ENERGY_W-1:0] den,
  output logic                         done,
  output logic [ips_pkg::SCORE_W-1:0]  quo
);
  import ips_pkg::*;

  localparam int STEP_W = $clog2(SCORE_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  dsh_r, dsh_nxt;
  logic [SCORE_W-1:0] quo_r, quo_nxt;
  logic              fit;

  assign fit = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SCORE_W - 1);
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (SCORE_W - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fit) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[SCORE_W-2:0], fit};
      dsh_nxt = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/ips_back.sv =====
// ----------------------------------------------------------------------------
// ips_back: window state and scoring back end
// Pops one command at a time, updates the window state, scores closed windows.
// ----------------------------------------------------------------------------
module ips_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ips_pkg::cmd_t                pop_cmd,
  input  logic                         pop_vld,
  output logic                         pop,
  input  logic [ips_pkg::ENERGY_W-1:0] full_scale,
  input  logic [ips_pkg::CNT_W-1:0]    window_ticks,
  ips_out_if.source                    out_ch
);
  import ips_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_START = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

  localparam int RISE5_W = ENERGY_W + 3;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic                active_r, active_nxt;
  logic [ENERGY_W-1:0] base_r, base_nxt;
  logic [ENERGY_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DECAY_W-1:0]  decay_r, decay_nxt;
  logic                onset_r, onset_nxt;
  logic [NUM_W-1:0]    prod_r;
  logic                sat_r;

  logic                out_vld_r, out_vld_nxt;
  logic                res_done_r, res_done_nxt;
  logic [SCORE_W-1:0]  res_score_r, res_score_nxt;
  logic                res_seen_r, res_seen_nxt;
  logic                res_open_r, res_open_nxt;

  logic                div_start, div_done;
  logic [SCORE_W-1:0]  div_quo;

  logic                gt_peak, over;
  logic [ENERGY_W-1:0] rise, imp;
  logic [RISE5_W-1:0]  rise5;

  assign pop     = (state_r == ST_IDLE) && pop_vld && !out_vld_r;
  assign gt_peak = (cmd_r.energy > peak_r);
  // onset test rise > fs/5 done as 5*rise > fs
  assign rise    = cmd_r.energy - base_r;
  assign rise5   = RISE5_W'({rise, 2'b00}) + RISE5_W'(rise);
  assign over    = (rise5 > RISE5_W'(full_scale));
  // peak never drops below baseline inside a window
  assign imp     = peak_r - base_r;

  always_comb begin
    logic [ENERGY_W-1:0] base_v, peak_v;
    logic [DECAY_W-1:0]  decay_v;
    logic [CNT_W-1:0]    cnt_v;
    logic                onset_v, close_v;

    state_nxt     = state_r;
    active_nxt    = active_r;
    base_nxt      = base_r;
    peak_nxt      = peak_r;
    cnt_nxt       = cnt_r;
    decay_nxt     = decay_r;
    onset_nxt     = onset_r;
    div_start     = 1'b0;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    res_done_nxt  = res_done_r;
    res_score_nxt = res_score_r;
    res_seen_nxt  = res_seen_r;
    res_open_nxt  = res_open_r;

    base_v  = base_r;
    peak_v  = peak_r;
    decay_v = decay_r;
    onset_v = onset_r;
    cnt_v   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    if (cnt_r == '0) begin
      base_v = cmd_r.energy;
      peak_v = cmd_r.energy;
    end else if (gt_peak) begin
      peak_v  = cmd_r.energy;
      decay_v = '0;
      if (over) begin
        onset_v = 1'b1;
      end
    end else if (onset_r && (decay_r < DECAY_TICKS)) begin
      decay_v = decay_r + 1'b1;
    end
    close_v = (cnt_v >= window_ticks) || (onset_v && (decay_v >= DECAY_TICKS));

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!cmd_r.func) begin
          // open a fresh window
          active_nxt    = 1'b1;
          base_nxt      = '0;
          peak_nxt      = '0;
          cnt_nxt       = '0;
          decay_nxt     = '0;
          onset_nxt     = 1'b0;
          out_vld_nxt   = 1'b1;
          res_done_nxt  = 1'b0;
          res_score_nxt = '0;
          res_seen_nxt  = 1'b0;
          res_open_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!active_r) begin
          // drop the sample, report held state
          out_vld_nxt   = 1'b1;
          res_done_nxt  = 1'b0;
          res_score_nxt = '0;
          res_seen_nxt  = onset_r;
          res_open_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          base_nxt  = base_v;
          peak_nxt  = peak_v;
          cnt_nxt   = cnt_v;
          decay_nxt = decay_v;
          onset_nxt = onset_v;
          if (close_v) begin
            active_nxt = 1'b0;
            state_nxt  = ST_MUL;
          end else begin
            out_vld_nxt   = 1'b1;
            res_done_nxt  = 1'b0;
            res_score_nxt = '0;
            res_seen_nxt  = onset_v;
            res_open_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        if (sat_r) begin
          out_vld_nxt   = 1'b1;
          res_done_nxt  = 1'b1;
          res_score_nxt = MAX_SCORE;
          res_seen_nxt  = onset_r;
          res_open_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          out_vld_nxt   = 1'b1;
          res_done_nxt  = 1'b1;
          res_score_nxt = div_quo;
          res_seen_nxt  = onset_r;
          res_open_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      active_r  <= 1'b0;
      base_r    <= '0;
      peak_r    <= '0;
      cnt_r     <= '0;
      decay_r   <= '0;
      onset_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      base_r    <= base_nxt;
      peak_r    <= peak_nxt;
      cnt_r     <= cnt_nxt;
      decay_r   <= decay_nxt;
      onset_r   <= onset_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= pop_cmd;
    end
    if (state_r == ST_MUL) begin
      prod_r <= NUM_W'(imp) * NUM_W'(MAX_SCORE);
      sat_r  <= (imp >= full_scale);
    end
    res_done_r  <= res_done_nxt;
    res_score_r <= res_score_nxt;
    res_seen_r  <= res_seen_nxt;
    res_open_r  <= res_open_nxt;
  end

  ips_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (full_scale),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_ch.valid        = out_vld_r;
  assign out_ch.window_done  = res_done_r;
  assign out_ch.impact_score = res_score_r;
  assign out_ch.impact_seen  = res_seen_r;
  assign out_ch.window_open  = res_open_r;

`ifndef SYNTHESIS
  a_peak_ge_base: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && (cnt_r != '0)) |-> (peak_r >= base_r))
    else $error("peak below baseline in an open window");

  a_decay_sat: assert property (@(posedge clk) disable iff (!rst_n)
    decay_r <= DECAY_TICKS)
    else $error("decay count past saturation");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_score_r <= MAX_SCORE))
    else $error("score out of range");

  a_done_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_done_r) |-> (!active_r && !res_open_r))
    else $error("closing result with window still open");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WAIT))
    else $error("divider finished outside wait state");
`endif

endmodule
